// ===== rtl/wdff_pkg.sv =====
// Shared widths, field positions and interface structs for the 802.11
// duplicate frame filter. No dependencies; used by every rtl file.
package wdff_pkg;

    localparam int WDFF_ENTRIES = 16;
    localparam int ADDR_W       = 48;
    localparam int SEQ_W        = 12;
    localparam int FRAG_W       = 4;
    localparam int SEQ_CTRL_W   = SEQ_W + FRAG_W;
    localparam int CNT_W        = 32;
    localparam int OCTET_W      = 8;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    localparam int FC0_CTRL_BIT  = 2;
    localparam int FC1_MORE_BIT  = 2;
    localparam int FC1_RETRY_BIT = 3;
    localparam int DST_GROUP_BIT = 0;

    typedef struct packed {
        logic              hit;
        logic              room;
        logic [SEQ_W-1:0]  seq;
        logic [FRAG_W-1:0] frag;
    } wdff_lookup_t;

    typedef struct packed {
        logic              clear;
        logic              update;
        logic [SEQ_W-1:0]  seq;
        logic [FRAG_W-1:0] frag;
    } wdff_write_t;

endpackage

// ===== rtl/wdff_table.sv =====
// Source address table: parallel address compare, first-free allocation
// and per-entry sequence/fragment storage. Depends on wdff_pkg.
module wdff_table #(
    parameter int ENTRIES = wdff_pkg::WDFF_ENTRIES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [wdff_pkg::ADDR_W-1:0] key,
    output wdff_pkg::wdff_lookup_t     look,
    input  wdff_pkg::wdff_write_t      wr
);
    import wdff_pkg::*;

    logic [ENTRIES-1:0] valid_reg;
    logic [ADDR_W-1:0]  addr_reg [ENTRIES];
    logic [SEQ_W-1:0]   seq_reg  [ENTRIES];
    logic [FRAG_W-1:0]  frag_reg [ENTRIES];

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] match_oh;
    logic [ENTRIES-1:0] free_oh;
    logic [ENTRIES-1:0] sel_oh;
    logic [SEQ_W-1:0]   seq_rd;
    logic [FRAG_W-1:0]  frag_rd;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (addr_reg[i] == key);
        end
    end

    assign match_oh = match & (~match + ENTRIES'(1));
    assign free_oh  = ~valid_reg & (valid_reg + ENTRIES'(1));
    assign sel_oh   = look.hit ? match_oh : free_oh;

    always_comb
    begin
        seq_rd  = '0;
        frag_rd = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match_oh[i])
            begin
                seq_rd  = seq_rd | seq_reg[i];
                frag_rd = frag_rd | frag_reg[i];
            end
        end
    end

    assign look.hit  = |match;
    assign look.room = ~&valid_reg;
    assign look.seq  = seq_rd;
    assign look.frag = frag_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.clear)
        begin
            valid_reg <= '0;
        end
        else if (wr.update)
        begin
            valid_reg <= valid_reg | sel_oh;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (wr.update && sel_oh[i])
            begin
                addr_reg[i] <= key;
                seq_reg[i]  <= wr.seq;
                frag_reg[i] <= wr.frag;
            end
        end
    end

endmodule

// ===== rtl/wifi_duplicate_frame_filter.sv =====
// Top level of the 802.11 receive duplicate filter: input register,
// filter decision, result register. Depends on wdff_pkg and wdff_table.
//
// One word is taken in every clock cycle; busy stays low. An accepted
// word is held in the input register, and its result is captured in the
// result register and shown with done high. The table lookup, decision
// and entry update all complete between the input and result registers,
// with no register in between, which lets back-to-back words from the
// same source see each other's updates. The receiver cannot stall: each
// result is present for exactly one cycle.
module wifi_duplicate_frame_filter #(
    parameter int ENTRIES = wdff_pkg::WDFF_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            kind,
    input  logic                            frame_short,
    input  logic [wdff_pkg::OCTET_W-1:0]    fc_first,
    input  logic [wdff_pkg::OCTET_W-1:0]    fc_second,
    input  logic [wdff_pkg::OCTET_W-1:0]    dst_first_octet,
    input  logic [wdff_pkg::SEQ_CTRL_W-1:0] seq_ctrl,
    input  logic [wdff_pkg::ADDR_W-1:0]     src_addr,
    output logic                            done,
    output logic                            forward,
    output logic                            duplicate,
    output logic [wdff_pkg::CNT_W-1:0]      dupe_total
);
    import wdff_pkg::*;

    logic                  in_valid_reg;
    logic                  kind_reg;
    logic                  short_reg;
    logic                  ctrl_reg;
    logic                  more_reg;
    logic                  retry_reg;
    logic                  group_reg;
    logic [SEQ_CTRL_W-1:0] seq_ctrl_reg;
    logic [ADDR_W-1:0]     src_addr_reg;

    logic                  done_reg;
    logic                  forward_reg;
    logic                  duplicate_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    wdff_lookup_t          look;
    wdff_write_t           wr;

    logic [SEQ_W-1:0]      seq;
    logic [FRAG_W-1:0]     frag;
    logic                  is_frag;
    logic                  checked;
    logic                  tracked;
    logic                  dup;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            kind_reg     <= kind;
            short_reg    <= frame_short;
            ctrl_reg     <= fc_first[FC0_CTRL_BIT];
            more_reg     <= fc_second[FC1_MORE_BIT];
            retry_reg    <= fc_second[FC1_RETRY_BIT];
            group_reg    <= dst_first_octet[DST_GROUP_BIT];
            seq_ctrl_reg <= seq_ctrl;
            src_addr_reg <= src_addr;
        end
    end

    wdff_table #(
        .ENTRIES(ENTRIES)
    ) u_table (
        .clk  (clk),
        .rst_n(rst_n),
        .key  (src_addr_reg),
        .look (look),
        .wr   (wr)
    );

    assign seq     = seq_ctrl_reg[SEQ_CTRL_W-1:FRAG_W];
    assign frag    = seq_ctrl_reg[FRAG_W-1:0];
    assign is_frag = (frag != '0) || more_reg;
    assign checked = in_valid_reg && (kind_reg == KIND_FRAME) && !short_reg
                     && !ctrl_reg && !group_reg;
    assign tracked = checked && (look.hit || look.room);
    assign dup     = tracked && retry_reg && (seq == look.seq)
                     && (!is_frag || (frag <= look.frag));

    always_comb
    begin
        wr.clear  = in_valid_reg && (kind_reg == KIND_CLEAR);
        wr.update = tracked;
        wr.seq    = dup ? look.seq : seq;
        wr.frag   = dup ? look.frag : frag;
    end

    always_comb
    begin
        count_next = count_reg;
        if (wr.clear)
        begin
            count_next = '0;
        end
        else if (dup)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg  <= in_valid_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        forward_reg   <= !(wr.clear || dup);
        duplicate_reg <= dup;
    end

    assign done       = done_reg;
    assign forward    = forward_reg;
    assign duplicate  = duplicate_reg;
    assign dupe_total = count_reg;

endmodule
